### src/assert_macros.svh
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/swbrl_pkg.sv
// Constants and types for the sliding window byte rate limiter
package swbrl_pkg;

  localparam int SLOTS          = 20;
  localparam int MAX_PAYLOAD    = 1458;
  localparam int HEADER_BYTES   = 12;
  localparam int OVERHEAD_BYTES = 8 + 20 + 14;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 32;

  localparam int S_TDATA_W = ((LEN_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = LEN_W + LEN_W + CNT_W + CNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] MAX_REQ    = LEN_W'(MAX_PAYLOAD - 1);
  localparam logic [LEN_W-1:0] WIRE_EXTRA = LEN_W'(HEADER_BYTES + OVERHEAD_BYTES);
  localparam logic [CNT_W-1:0] OVERHEAD   = CNT_W'(OVERHEAD_BYTES);

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_t;

  typedef enum logic {
    REG_WINDOW_BUDGET = 1'b0,
    REG_SLOT_BUDGET   = 1'b1
  } reg_idx_t;

endpackage

### src/sliding_window_byte_rate_limiter.sv
// Sliding window byte rate limiter: per-packet admission against window and slot budgets
//
// Input channel (s_*): one transaction per item. s_tuser carries the op (tick or
// send request), s_tdata the requested payload length. Every item gives exactly
// one result on the output channel (m_*): m_tuser is the grant flag, m_tdata
// holds payload length, wire length, sequence number and window byte total.
// A tick retires the oldest slot of the ring and opens a new burst; a request
// is granted or denied against the budgets written on the config port.
// The config port (cfg_*) is always ready; write it only while the block is idle.
// An item passes through the input register, then the result register, before
// its result appears on m_*. Throughput: one item per cycle while m_tready stays
// high, set by the read-modify-write of the window and burst counters that each
// item makes as it moves into the result register.
// When m_tready is low the result register holds, the input register fills,
// and s_tready drops until the result is taken; nothing is lost or repeated.
// Reset (rst, synchronous) clears all counters, the ring, both budgets and
// both valid flags; the burst stays closed until the first tick.
`include "assert_macros.svh"

module sliding_window_byte_rate_limiter import swbrl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [10:0] requested_len, rest zero
  input  logic [0:0]           s_tuser,   // [0] op
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // payload_len, wire_len, seq_num, window_used
  output logic [0:0]           m_tuser,   // [0] granted
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_addr,
  input  logic [CNT_W-1:0]     cfg_data
);

  // configuration
  count_t window_budget;
  count_t slot_budget;

  // limiter state
  count_t    slot_bytes [SLOTS];
  slot_idx_t current_slot;
  count_t    window_total;
  count_t    burst_total;
  logic      burst_open;
  count_t    next_seq;

  // input register
  logic in_valid;
  op_t  in_op;
  len_t in_req;

  // result register
  logic   out_valid;
  logic   out_granted;
  len_t   out_pay;
  len_t   out_wire;
  count_t out_seq;
  count_t out_used;

  logic advance;
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // decision logic
  slot_idx_t oldest;
  count_t    room;
  len_t      req_sat;
  count_t    req_need;
  logic      budget_ok;
  logic      ok;
  len_t      pay;
  len_t      wire_bytes;
  count_t    wire_ext;
  count_t    window_next;

  always_comb begin
    oldest    = (current_slot == SLOT_W'(SLOTS - 1)) ? '0 : current_slot + 1'b1;
    room      = window_budget - window_total;
    req_sat   = (in_req > MAX_REQ) ? MAX_REQ : in_req;
    req_need  = CNT_W'(req_sat) + OVERHEAD;
    budget_ok = burst_open && (window_total < window_budget) &&
                (burst_total < slot_budget);
    ok        = budget_ok;
    pay       = req_sat;
    if (req_need > room) begin
      if (room < OVERHEAD) begin
        ok = 1'b0;
      end else begin
        pay = LEN_W'(room - OVERHEAD);
      end
    end
    wire_bytes = pay + WIRE_EXTRA;
    wire_ext   = CNT_W'(wire_bytes);
    if (in_op == OP_TICK) begin
      window_next = window_total - slot_bytes[oldest];
    end else if (ok) begin
      window_next = window_total + wire_ext;
    end else begin
      window_next = window_total;
    end
  end

  logic grant;
  assign grant = (in_op == OP_SEND) && ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_budget <= '0;
      slot_budget   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_WINDOW_BUDGET: window_budget <= cfg_data;
        REG_SLOT_BUDGET:   slot_budget   <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= op_t'(s_tuser[0]);
      in_req <= s_tdata[LEN_W-1:0];
    end
  end

  // limiter state; the current slot's count lives in burst_total and is
  // stored back into the ring when a tick leaves that slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_bytes[i] <= '0;
      end
      current_slot <= '0;
      window_total <= '0;
      burst_total  <= '0;
      burst_open   <= 1'b0;
      next_seq     <= '0;
    end else if (advance) begin
      window_total <= window_next;
      if (in_op == OP_TICK) begin
        slot_bytes[current_slot] <= burst_total;
        current_slot <= oldest;
        burst_total  <= '0;
        burst_open   <= 1'b1;
      end else if (ok) begin
        burst_total <= burst_total + wire_ext;
        next_seq    <= next_seq + 1'b1;
      end else begin
        burst_open <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_granted <= grant;
      out_pay     <= grant ? pay  : '0;
      out_wire    <= grant ? wire_bytes : '0;
      out_seq     <= grant ? next_seq : '0;
      out_used    <= window_next;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tuser[0] = out_granted;
  assign m_tdata    = M_TDATA_W'({out_used, out_seq, out_wire, out_pay});

  `ASSERT_IMPL(a_grant_wire_len, out_valid && out_granted,
               out_wire == out_pay + WIRE_EXTRA, "wire length does not match payload")
  `ASSERT_IMPL(a_deny_zero, out_valid && !out_granted,
               out_pay == '0 && out_wire == '0 && out_seq == '0,
               "denied or tick result carries nonzero fields")
  `ASSERT_NEXT(a_tick_opens, advance && in_op == OP_TICK,
               burst_open && burst_total == '0, "tick did not open a fresh burst")
  `ASSERT_NEXT(a_deny_closes, advance && in_op == OP_SEND && !ok,
               !burst_open && $stable(next_seq), "denial left burst open or moved sequence")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the sliding window byte rate limiter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swbrl_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic   granted;
    len_t   payload_len;
    len_t   wire_len;
    count_t seq_num;
    count_t window_used;
  } verdict_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // [10:0] requested_len, rest zero
  logic [0:0]           s_tuser = '0;   // [0] op
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // payload_len, wire_len, seq_num, window_used
  logic [0:0]           m_tuser;        // [0] granted
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [0:0]           cfg_addr = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  // shaper state as the block should hold it
  count_t    ring [SLOTS];
  slot_idx_t cur_slot = '0;
  count_t    win_total = '0;
  count_t    burst_bytes = '0;
  logic      burst_on = 1'b0;
  count_t    seq_next = '0;
  count_t    win_budget = '0;
  count_t    burst_budget = '0;

  verdict_t expected_verdicts[$];
  int       mismatch_count = 0;
  int       stall_cycles = 0;
  bit       steady = 1'b0;

  sliding_window_byte_rate_limiter dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) ring[i] = '0;
  end

  // Admission decision for one item; updates the shaper state
  function automatic verdict_t admit(op_t op, len_t req);
    verdict_t v;
    int       oldest;
    count_t   room;
    count_t   pay;
    count_t   charge;
    logic     ok;
    v = '{granted: 1'b0, payload_len: '0, wire_len: '0, seq_num: '0, window_used: '0};
    if (op == OP_TICK) begin
      oldest = (int'(cur_slot) + 1) % SLOTS;
      win_total = win_total - ring[oldest];
      ring[oldest] = '0;
      cur_slot = slot_idx_t'(oldest);
      burst_bytes = '0;
      burst_on = 1'b1;
    end else begin
      ok = burst_on && (win_total < win_budget) && (burst_bytes < burst_budget);
      pay = count_t'(req);
      if (ok) begin
        room = win_budget - win_total;
        if (pay > count_t'(MAX_PAYLOAD - 1)) pay = count_t'(MAX_PAYLOAD - 1);
        // clamp to the room left; header bytes are not part of this fit
        if (pay + count_t'(OVERHEAD_BYTES) > room) begin
          if (room < count_t'(OVERHEAD_BYTES)) ok = 1'b0;
          else pay = room - count_t'(OVERHEAD_BYTES);
        end
      end
      if (ok) begin
        charge = pay + count_t'(HEADER_BYTES + OVERHEAD_BYTES);
        v.granted = 1'b1;
        v.payload_len = len_t'(pay);
        v.wire_len = len_t'(charge);
        v.seq_num = seq_next;
        seq_next = seq_next + 1;
        ring[cur_slot] = ring[cur_slot] + charge;
        win_total = win_total + charge;
        burst_bytes = burst_bytes + charge;
      end else begin
        burst_on = 1'b0;
      end
    end
    v.window_used = win_total;
    return v;
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_item(input op_t op, input len_t len);
    while (!steady && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= S_TDATA_W'(len);
    do @(posedge clk); while (!s_tready);
    expected_verdicts.push_back(admit(op, len));
  endtask

  // Hold off the sender until every pending result is back
  task automatic finish_outstanding();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  task automatic set_budgets(input count_t win, input count_t per_slot);
    finish_outstanding();
    cfg_valid <= 1'b1;
    cfg_addr <= REG_WINDOW_BUDGET;
    cfg_data <= win;
    do @(posedge clk); while (!cfg_ready);
    win_budget = win;
    cfg_addr <= REG_SLOT_BUDGET;
    cfg_data <= per_slot;
    do @(posedge clk); while (!cfg_ready);
    burst_budget = per_slot;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n, input int tick_pct, input bit pause_midway);
    int   roll;
    len_t len;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) finish_outstanding();
      roll = $urandom_range(99);
      if (roll < 5) len = len_t'($urandom_range(2047, MAX_PAYLOAD));
      else if (roll < 12) len = $urandom_range(1) ? len_t'(MAX_PAYLOAD - 1) : len_t'(0);
      else len = len_t'($urandom_range(MAX_PAYLOAD - 1));
      send_item(($urandom_range(99) < tick_pct) ? OP_TICK : OP_SEND, len);
    end
  endtask

  // Budgets are zero and the burst is closed until the first tick
  task automatic test_closed_burst();
    send_item(OP_SEND, '0);
    send_item(OP_SEND, len_t'(MAX_PAYLOAD - 1));
    send_item(OP_TICK, '0);
    send_item(OP_SEND, len_t'(100));
    send_item(OP_SEND, len_t'(5));
  endtask

  // Unlimited budgets: field extremes and oversized requests
  task automatic test_full_budgets();
    set_budgets('1, '1);
    send_item(OP_TICK, len_t'(2047));
    send_item(OP_SEND, '0);
    send_item(OP_SEND, len_t'(MAX_PAYLOAD - 1));
    send_item(OP_SEND, len_t'(MAX_PAYLOAD));
    send_item(OP_SEND, len_t'(2047));
    send_item(OP_SEND, len_t'(1024));
    send_item(OP_SEND, len_t'(1023));
  endtask

  // Window nearly full: clamp, and deny when less than the overhead fits
  task automatic test_window_clamp();
    finish_outstanding();
    set_budgets(win_total + 180, '1);
    send_item(OP_TICK, '0);
    send_item(OP_SEND, len_t'(100));
    send_item(OP_SEND, len_t'(50));
    set_budgets(win_total + 146, '1);
    send_item(OP_TICK, '0);
    send_item(OP_SEND, len_t'(MAX_PAYLOAD - 1));
    send_item(OP_SEND, len_t'(1));
  endtask

  // Slot budget closes the burst; only a tick reopens it
  task automatic test_slot_budget();
    set_budgets('1, count_t'(100));
    send_item(OP_TICK, '0);
    send_item(OP_SEND, len_t'(10));
    send_item(OP_SEND, len_t'(10));
    send_item(OP_SEND, len_t'(10));
    send_item(OP_SEND, len_t'(10));
    send_item(OP_TICK, '0);
    send_item(OP_SEND, len_t'(10));
  endtask

  task automatic test_random_shaping();
    count_t win;
    win = count_t'($urandom_range(80000, 5000));
    set_budgets(win, win / SLOTS);
    run_traffic(450, 15, 1'b1);
  endtask

  task automatic test_back_to_back();
    set_budgets('1, '1);
    steady = 1'b1;
    run_traffic(300, 10, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_tight();
    finish_outstanding();
    set_budgets(win_total + count_t'($urandom_range(3000)), count_t'($urandom_range(500)));
    run_traffic(400, 25, 1'b0);
  endtask

  task automatic test_random_budgets();
    set_budgets(count_t'($urandom), count_t'($urandom));
    run_traffic(150, 15, 1'b0);
    set_budgets('1, count_t'($urandom_range(3000)));
    run_traffic(150, 15, 1'b0);
    set_budgets('0, '1);
    run_traffic(150, 20, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_closed_burst();
    test_full_budgets();
    test_window_clamp();
    test_slot_budget();
    test_random_shaping();
    test_back_to_back();
    test_random_tight();
    test_random_budgets();
    finish_outstanding();
    repeat (8) @(posedge clk);
    if (expected_verdicts.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Compare each result transaction and drive the receiver stalls
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_verdicts.size() == 0) begin
        report_error("result with nothing pending");
      end else begin
        want = expected_verdicts.pop_front();
        if (m_tuser[0] !== want.granted)
          report_error($sformatf("granted got %0h want %0h", m_tuser[0], want.granted));
        if (m_tdata[LEN_W-1:0] !== want.payload_len)
          report_error($sformatf("payload_len got %0d want %0d",
                                 m_tdata[LEN_W-1:0], want.payload_len));
        if (m_tdata[LEN_W +: LEN_W] !== want.wire_len)
          report_error($sformatf("wire_len got %0d want %0d",
                                 m_tdata[LEN_W +: LEN_W], want.wire_len));
        if (m_tdata[2*LEN_W +: CNT_W] !== want.seq_num)
          report_error($sformatf("seq_num got %0h want %0h",
                                 m_tdata[2*LEN_W +: CNT_W], want.seq_num));
        if (m_tdata[2*LEN_W+CNT_W +: CNT_W] !== want.window_used)
          report_error($sformatf("window_used got %0h want %0h",
                                 m_tdata[2*LEN_W+CNT_W +: CNT_W], want.window_used));
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 38);
  end

  // End the run when no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

endmodule

### sim.f
+incdir+src
src/swbrl_pkg.sv
src/sliding_window_byte_rate_limiter.sv
tb/sv/tb.sv
